// ----- hdl/hcd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcd_pkg
// Types and constants shared by the chunked body decoder modules.
// ----------------------------------------------------------------------------
package hcd_pkg;

   localparam int CONTENT_LENGTH_WIDTH = 31;

   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_COLON = 8'd58;

   localparam logic OP_START = 1'b0;
   localparam logic OP_BYTE  = 1'b1;

   localparam logic REG_CHUNKED_MODE   = 1'b0;
   localparam logic REG_CONTENT_LENGTH = 1'b1;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_LEN  = 3'd1,
      PH_SIZE = 3'd2,
      PH_DATA = 3'd3,
      PH_DEND = 3'd4,
      PH_TRL  = 3'd5,
      PH_DONE = 3'd6,
      PH_ERR  = 3'd7
   } phase_type;

   typedef enum logic [1:0] {
      K_NONE = 2'd0,
      K_BYTE = 2'd1,
      K_DONE = 2'd2,
      K_ERR  = 2'd3
   } kind_type;

   typedef struct packed {
      logic                            chunked_mode;
      logic [CONTENT_LENGTH_WIDTH-1:0] content_length;
   } cfg_type;

   typedef struct packed {
      logic size_digit_seen;
      logic pending_cr;
      logic line_nonempty;
      logic colon_seen;
   } line_flags_type;

   // {valid, nibble}
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] res;
      res = 5'd0;
      if (c >= 8'd48 && c <= 8'd57) begin
         res = {1'b1, 4'(c - 8'd48)};
      end else if (c >= 8'd65 && c <= 8'd70) begin
         res = {1'b1, 4'(c - 8'd55)};
      end else if (c >= 8'd97 && c <= 8'd102) begin
         res = {1'b1, 4'(c - 8'd87)};
      end
      return res;
   endfunction

endpackage

// ----- hdl/hcd_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcd_req_if
// Input channel: start items and body bytes.
// ----------------------------------------------------------------------------
interface hcd_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] data_in;

   modport source (output valid, output op, output data_in, input ready);
   modport sink (input valid, input op, input data_in, output ready);
endinterface

// ----- hdl/hcd_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcd_rsp_if
// Result channel: one result beat per input beat.
// ----------------------------------------------------------------------------
interface hcd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] data_out;

   modport source (output valid, output kind, output data_out, input ready);
   modport sink (input valid, input kind, input data_out, output ready);
endinterface

// ----- hdl/hcd_csr.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcd_csr
// APB register file holding the body mode and the content length.
// ----------------------------------------------------------------------------
module hcd_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready,
   output hcd_pkg::cfg_type  cfg
);

   hcd_pkg::cfg_type cfg_ff, cfg_in;
   logic             wr_en;

   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (csr_paddr[2])
            hcd_pkg::REG_CHUNKED_MODE:   cfg_in.chunked_mode = csr_pwdata[0];
            hcd_pkg::REG_CONTENT_LENGTH:
               cfg_in.content_length = csr_pwdata[hcd_pkg::CONTENT_LENGTH_WIDTH-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         hcd_pkg::REG_CHUNKED_MODE:   csr_prdata = {31'd0, cfg_ff.chunked_mode};
         hcd_pkg::REG_CONTENT_LENGTH: csr_prdata = {1'b0, cfg_ff.content_length};
         default:                     csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.chunked_mode   <= 1'b1;
         cfg_ff.content_length <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- hdl/hcd_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcd_step
// Per-beat decode: next phase, counter and line flags, and the result beat.
// ----------------------------------------------------------------------------
module hcd_step #(
   parameter int SIZE_BITS = 31,
   parameter int REM_W     = 31
) (
   input  logic                  op,
   input  logic [7:0]            c,
   input  hcd_pkg::cfg_type      cfg,
   input  hcd_pkg::phase_type    phase,
   input  logic [REM_W-1:0]      rem,
   input  hcd_pkg::line_flags_type flags,
   output hcd_pkg::phase_type    phase_nxt,
   output logic [REM_W-1:0]      rem_nxt,
   output hcd_pkg::line_flags_type flags_nxt,
   output hcd_pkg::kind_type     kind,
   output logic [7:0]            data_out
);

   logic             is_cr, is_lf, is_colon;
   logic [4:0]       hex;
   logic             size_ovf;
   logic [REM_W-1:0] rem_dec;
   logic             rem_last;
   logic             sz_fail, dend_fail, trl_fail, trl_done;
   logic             cl_zero;

   assign is_cr    = (c == hcd_pkg::CH_CR);
   assign is_lf    = (c == hcd_pkg::CH_LF);
   assign is_colon = (c == hcd_pkg::CH_COLON);
   assign hex      = hcd_pkg::hex_value(c);
   assign size_ovf = (rem[REM_W-1:SIZE_BITS-4] != '0);
   assign rem_dec  = rem - REM_W'(1);
   assign rem_last = (rem_dec == '0);
   assign cl_zero  = (cfg.content_length == '0);

   assign sz_fail   = flags.pending_cr ? !is_lf :
                      is_cr ? !flags.size_digit_seen : (!hex[4] | size_ovf);
   assign dend_fail = flags.pending_cr ? !is_lf : !is_cr;
   assign trl_done  = flags.pending_cr & is_lf & !flags.line_nonempty;
   // a colon may not open a trailer line; a closed line must have held one
   assign trl_fail  = (flags.pending_cr & is_lf & flags.line_nonempty & !flags.colon_seen)
                    | (!flags.pending_cr & !flags.line_nonempty & is_colon);

   // next state
   always_comb begin
      phase_nxt = phase;
      rem_nxt   = rem;
      flags_nxt = flags;
      if (op == hcd_pkg::OP_START) begin
         flags_nxt = '0;
         rem_nxt   = '0;
         if (cfg.chunked_mode) begin
            phase_nxt = hcd_pkg::PH_SIZE;
         end else if (cl_zero) begin
            phase_nxt = hcd_pkg::PH_DONE;
         end else begin
            phase_nxt = hcd_pkg::PH_LEN;
            rem_nxt   = REM_W'(cfg.content_length);
         end
      end else begin
         unique case (phase)
            hcd_pkg::PH_LEN: begin
               rem_nxt = rem_dec;
               if (rem_last) begin
                  phase_nxt            = hcd_pkg::PH_DONE;
                  flags_nxt.pending_cr = 1'b1;
               end
            end
            hcd_pkg::PH_SIZE: begin
               if (sz_fail) begin
                  phase_nxt = hcd_pkg::PH_ERR;
               end else if (flags.pending_cr) begin
                  flags_nxt = '0;
                  phase_nxt = (rem != '0) ? hcd_pkg::PH_DATA : hcd_pkg::PH_TRL;
               end else if (is_cr) begin
                  flags_nxt.pending_cr = 1'b1;
               end else begin
                  rem_nxt                   = {rem[REM_W-5:0], hex[3:0]};
                  flags_nxt.size_digit_seen = 1'b1;
               end
            end
            hcd_pkg::PH_DATA: begin
               rem_nxt = rem_dec;
               if (rem_last) begin
                  phase_nxt            = hcd_pkg::PH_DEND;
                  flags_nxt.pending_cr = 1'b0;
               end
            end
            hcd_pkg::PH_DEND: begin
               if (dend_fail) begin
                  phase_nxt = hcd_pkg::PH_ERR;
               end else if (flags.pending_cr) begin
                  phase_nxt                 = hcd_pkg::PH_SIZE;
                  flags_nxt.pending_cr      = 1'b0;
                  flags_nxt.size_digit_seen = 1'b0;
                  rem_nxt                   = '0;
               end else begin
                  flags_nxt.pending_cr = 1'b1;
               end
            end
            hcd_pkg::PH_TRL: begin
               if (trl_fail) begin
                  phase_nxt = hcd_pkg::PH_ERR;
               end else if (trl_done) begin
                  phase_nxt            = hcd_pkg::PH_DONE;
                  flags_nxt.pending_cr = 1'b0;
               end else if (flags.pending_cr & is_lf) begin
                  flags_nxt.pending_cr    = 1'b0;
                  flags_nxt.line_nonempty = 1'b0;
                  flags_nxt.colon_seen    = 1'b0;
               end else begin
                  // a held CR that is not followed by LF counts as a line byte
                  flags_nxt.pending_cr    = is_cr;
                  flags_nxt.line_nonempty = is_cr ? (flags.line_nonempty | flags.pending_cr)
                                                  : 1'b1;
                  flags_nxt.colon_seen    = flags.colon_seen
                                          | (is_colon & (flags.line_nonempty | flags.pending_cr));
               end
            end
            hcd_pkg::PH_DONE: flags_nxt.pending_cr = 1'b0;
            default: phase_nxt = phase;
         endcase
      end
   end

   // result beat
   always_comb begin
      kind     = hcd_pkg::K_NONE;
      data_out = 8'd0;
      if (op == hcd_pkg::OP_START) begin
         if (!cfg.chunked_mode && cl_zero) begin
            kind = hcd_pkg::K_DONE;
         end
      end else begin
         unique case (phase)
            hcd_pkg::PH_LEN, hcd_pkg::PH_DATA: begin
               kind     = hcd_pkg::K_BYTE;
               data_out = c;
            end
            hcd_pkg::PH_SIZE: if (sz_fail) kind = hcd_pkg::K_ERR;
            hcd_pkg::PH_DEND: if (dend_fail) kind = hcd_pkg::K_ERR;
            hcd_pkg::PH_TRL: begin
               if (trl_fail) begin
                  kind = hcd_pkg::K_ERR;
               end else if (trl_done) begin
                  kind = hcd_pkg::K_DONE;
               end
            end
            hcd_pkg::PH_DONE: if (flags.pending_cr) kind = hcd_pkg::K_DONE;
            hcd_pkg::PH_ERR:  kind = hcd_pkg::K_ERR;
            default:          kind = hcd_pkg::K_NONE;
         endcase
      end
   end

endmodule

// ----- hdl/http_chunked_body_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// HTTP/1.1 body decoder for length-delimited and chunked bodies, one byte a beat.
// ----------------------------------------------------------------------------
//  channel  | role      | beat contents
//  req_ch   | sink      | op (start / byte), data_in
//  rsp_ch   | source    | kind (none / byte / done / error), data_out
//  csr_*    | APB slave | reg 0 chunked_mode @0x0, reg 1 content_length @0x4
//
//  One beat per cycle sustained while results are taken; every input beat
//  gives one result beat. A beat passes an input register, then the decode
//  into the result register. A stalled result holds the pipe; the input register
//  refills as soon as the result register frees. Synchronous reset clears the
//  decoder to idle and loads chunked mode with a content length of zero.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder #(
   parameter int SIZE_BITS = 31
) (
   input  logic        clock,
   input  logic        reset,
   hcd_req_if.sink     req_ch,
   hcd_rsp_if.source   rsp_ch,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int REM_W = (SIZE_BITS > hcd_pkg::CONTENT_LENGTH_WIDTH) ?
                          SIZE_BITS : hcd_pkg::CONTENT_LENGTH_WIDTH;

   hcd_pkg::cfg_type        cfg;

   logic                    in_valid_ff;
   logic                    in_op_ff;
   logic [7:0]              in_data_ff;

   hcd_pkg::phase_type      phase_ff, phase_in;
   logic [REM_W-1:0]        rem_ff, rem_in;
   hcd_pkg::line_flags_type flags_ff, flags_in;

   logic                    out_valid_ff;
   hcd_pkg::kind_type       out_kind_ff, out_kind_in;
   logic [7:0]              out_data_ff, out_data_in;

   logic                    advance;

   hcd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   hcd_step #(
      .SIZE_BITS (SIZE_BITS),
      .REM_W     (REM_W)
   ) u_step (
      .op        (in_op_ff),
      .c         (in_data_ff),
      .cfg       (cfg),
      .phase     (phase_ff),
      .rem       (rem_ff),
      .flags     (flags_ff),
      .phase_nxt (phase_in),
      .rem_nxt   (rem_in),
      .flags_nxt (flags_in),
      .kind      (out_kind_in),
      .data_out  (out_data_in)
   );

   // advance the held beat once the result register is free
   assign advance      = in_valid_ff & (!out_valid_ff | rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff | advance;

   assign rsp_ch.valid    = out_valid_ff;
   assign rsp_ch.kind     = out_kind_ff;
   assign rsp_ch.data_out = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= hcd_pkg::PH_IDLE;
         rem_ff       <= '0;
         flags_ff     <= '0;
      end else begin
         if (req_ch.ready) begin
            in_valid_ff <= req_ch.valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            phase_ff     <= phase_in;
            rem_ff       <= rem_in;
            flags_ff     <= flags_in;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_op_ff   <= req_ch.op;
         in_data_ff <= req_ch.data_in;
      end
      if (advance) begin
         out_kind_ff <= out_kind_in;
         out_data_ff <= out_data_in;
      end
   end

endmodule

// ----- bench/http_chunked_body_decoder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_tb
// Drives start items and body bytes into the decoder with random gaps and
// result stalls, predicts every result beat from a behavioural decoder kept
// in the bench, and checks each result beat field by field in order.
// Covers chunked bodies, clean and corrupted, as well as length-delimited
// bodies across several register settings.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_tb;

   localparam int          SIZE_W       = 31;
   localparam int unsigned ITEM_TARGET  = 1200;
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned DRAIN_CYCLES = 8;

   localparam logic [2:0] ADDR_CHUNKED_MODE   = {hcd_pkg::REG_CHUNKED_MODE, 2'b00};
   localparam logic [2:0] ADDR_CONTENT_LENGTH = {hcd_pkg::REG_CONTENT_LENGTH, 2'b00};

   typedef struct packed {
      logic       op;
      logic [7:0] value;
   } body_item_type;

   typedef struct packed {
      hcd_pkg::kind_type kind;
      logic [7:0]        data;
   } body_beat_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   hcd_req_if req_ch ();
   hcd_rsp_if rsp_ch ();

   // register copies as last written
   logic                                     chunked_cfg = 1'b1;
   logic [hcd_pkg::CONTENT_LENGTH_WIDTH-1:0] length_cfg  = '0;

   // decoder state
   hcd_pkg::phase_type                       stage       = hcd_pkg::PH_IDLE;
   logic [hcd_pkg::CONTENT_LENGTH_WIDTH-1:0] left        = '0;
   logic                                     digit_seen  = 1'b0;
   logic                                     cr_wait     = 1'b0;
   logic                                     line_open   = 1'b0;
   logic                                     colon_hit   = 1'b0;

   body_item_type  pending[$];
   body_beat_type  expected[$];
   logic [7:0]     scratch[$];

   int unsigned items_pushed = 0;
   int unsigned errors       = 0;
   int unsigned cycles       = 0;
   int unsigned src_gap      = 0;
   int unsigned sink_gap     = 0;
   bit          src_idles    = 1'b0;
   bit          sink_idles   = 1'b0;

   http_chunked_body_decoder #(
      .SIZE_BITS (SIZE_W)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Decoder prediction
   // ------------------------------------------------------------------------
   function automatic hcd_pkg::kind_type fault();
      stage = hcd_pkg::PH_ERR;
      return hcd_pkg::K_ERR;
   endfunction

   function automatic void clear_line_flags();
      cr_wait   = 1'b0;
      line_open = 1'b0;
      colon_hit = 1'b0;
   endfunction

   // ordinary byte of a trailer line; a leading colon is malformed
   function automatic hcd_pkg::kind_type trailer_text(input logic [7:0] c);
      if (!line_open) begin
         line_open = 1'b1;
         if (c == hcd_pkg::CH_COLON) begin
            return fault();
         end
      end else if (c == hcd_pkg::CH_COLON) begin
         colon_hit = 1'b1;
      end
      return hcd_pkg::K_NONE;
   endfunction

   function automatic hcd_pkg::kind_type trailer_line_byte(input logic [7:0] c);
      if (cr_wait) begin
         cr_wait = 1'b0;
         if (c == hcd_pkg::CH_LF) begin
            if (!line_open) begin
               stage = hcd_pkg::PH_DONE;
               return hcd_pkg::K_DONE;
            end
            if (!colon_hit) begin
               return fault();
            end
            clear_line_flags();
            return hcd_pkg::K_NONE;
         end
         // lone CR counts as line content
         if (trailer_text(hcd_pkg::CH_CR) == hcd_pkg::K_ERR) begin
            return hcd_pkg::K_ERR;
         end
      end
      if (c == hcd_pkg::CH_CR) begin
         cr_wait = 1'b1;
         return hcd_pkg::K_NONE;
      end
      return trailer_text(c);
   endfunction

   function automatic hcd_pkg::kind_type size_line_byte(input logic [7:0] c);
      logic [3:0] nib;
      logic       nib_ok;
      nib    = 4'd0;
      nib_ok = 1'b1;
      if (cr_wait) begin
         if (c != hcd_pkg::CH_LF) begin
            return fault();
         end
         cr_wait    = 1'b0;
         digit_seen = 1'b0;
         if (left != 0) begin
            stage = hcd_pkg::PH_DATA;
         end else begin
            stage = hcd_pkg::PH_TRL;
            clear_line_flags();
         end
         return hcd_pkg::K_NONE;
      end
      if (c == hcd_pkg::CH_CR) begin
         if (!digit_seen) begin
            return fault();
         end
         cr_wait = 1'b1;
         return hcd_pkg::K_NONE;
      end
      if (c >= 8'h30 && c <= 8'h39) begin
         nib = 4'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         nib = 4'(c - 8'h37);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         nib = 4'(c - 8'h57);
      end else begin
         nib_ok = 1'b0;
      end
      if (!nib_ok) begin
         return fault();
      end
      // one more digit would not fit
      if (left[SIZE_W-1 -: 4] != 4'd0) begin
         return fault();
      end
      left       = {left[SIZE_W-5:0], nib};
      digit_seen = 1'b1;
      return hcd_pkg::K_NONE;
   endfunction

   task automatic decode_beat(input logic op, input logic [7:0] c);
      hcd_pkg::kind_type k;
      logic [7:0]        d;
      k = hcd_pkg::K_NONE;
      d = 8'd0;
      if (op == hcd_pkg::OP_START) begin
         digit_seen = 1'b0;
         clear_line_flags();
         left = '0;
         if (chunked_cfg) begin
            stage = hcd_pkg::PH_SIZE;
         end else if (length_cfg == 0) begin
            stage = hcd_pkg::PH_DONE;
            k     = hcd_pkg::K_DONE;
         end else begin
            stage = hcd_pkg::PH_LEN;
            left  = length_cfg;
         end
      end else begin
         case (stage)
            hcd_pkg::PH_LEN: begin
               k    = hcd_pkg::K_BYTE;
               d    = c;
               left = left - 1'b1;
               if (left == 0) begin
                  // completion goes out on the following byte
                  stage   = hcd_pkg::PH_DONE;
                  cr_wait = 1'b1;
               end
            end
            hcd_pkg::PH_SIZE: begin
               k = size_line_byte(c);
            end
            hcd_pkg::PH_DATA: begin
               k    = hcd_pkg::K_BYTE;
               d    = c;
               left = left - 1'b1;
               if (left == 0) begin
                  stage   = hcd_pkg::PH_DEND;
                  cr_wait = 1'b0;
               end
            end
            hcd_pkg::PH_DEND: begin
               if (!cr_wait) begin
                  if (c == hcd_pkg::CH_CR) begin
                     cr_wait = 1'b1;
                  end else begin
                     k = fault();
                  end
               end else begin
                  cr_wait = 1'b0;
                  if (c == hcd_pkg::CH_LF) begin
                     stage      = hcd_pkg::PH_SIZE;
                     digit_seen = 1'b0;
                     left       = '0;
                  end else begin
                     k = fault();
                  end
               end
            end
            hcd_pkg::PH_TRL: begin
               k = trailer_line_byte(c);
            end
            hcd_pkg::PH_DONE: begin
               if (cr_wait) begin
                  cr_wait = 1'b0;
                  k       = hcd_pkg::K_DONE;
               end
            end
            hcd_pkg::PH_ERR: begin
               k = hcd_pkg::K_ERR;
            end
            default: ;
         endcase
      end
      expected.push_back('{k, d});
   endtask

   // ------------------------------------------------------------------------
   // Stimulus building
   // ------------------------------------------------------------------------
   task automatic push_item(input logic op, input logic [7:0] value);
      pending.push_back('{op, value});
      items_pushed++;
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         scratch.push_back(s[i]);
      end
   endtask

   task automatic add_crlf();
      scratch.push_back(hcd_pkg::CH_CR);
      scratch.push_back(hcd_pkg::CH_LF);
   endtask

   task automatic add_hex(input logic [31:0] value);
      logic [7:0] digits[$];
      logic [3:0] nib;
      bit         upper;
      upper = 1'($urandom_range(0, 1));
      do begin
         nib = value[3:0];
         digits.push_front(nib < 4'd10 ? 8'h30 + nib : (upper ? 8'h37 : 8'h57) + nib);
         value = value >> 4;
      end while (value != 0);
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 3)) digits.push_front(8'h30);
      end
      foreach (digits[i]) begin
         scratch.push_back(digits[i]);
      end
   endtask

   // letter, then content holding a colon, bare LFs and lone CRs, then CRLF
   task automatic add_trailer_line();
      int unsigned n;
      int unsigned colon_at;
      logic [7:0]  c;
      scratch.push_back(8'h41 + 8'($urandom_range(0, 25)));
      n        = $urandom_range(0, 4);
      colon_at = $urandom_range(0, n);
      for (int i = 0; i <= n; i++) begin
         if (i == colon_at) begin
            scratch.push_back(hcd_pkg::CH_COLON);
         end else begin
            case ($urandom_range(0, 7))
               0: begin
                  scratch.push_back(hcd_pkg::CH_LF);
               end
               1: begin
                  scratch.push_back(hcd_pkg::CH_CR);
                  scratch.push_back(8'h78);
               end
               default: begin
                  c = 8'($urandom_range(0, 255));
                  scratch.push_back(c == hcd_pkg::CH_CR ? 8'h78 : c);
               end
            endcase
         end
      end
      add_crlf();
   endtask

   task automatic make_chunked_body();
      int unsigned sz;
      int unsigned r;
      repeat ($urandom_range(0, 3)) begin
         r = $urandom_range(0, 63);
         if (r == 0) begin
            sz = $urandom_range(256, 300);
         end else if (r < 8) begin
            sz = $urandom_range(7, 40);
         end else begin
            sz = $urandom_range(1, 6);
         end
         add_hex(sz);
         add_crlf();
         repeat (sz) scratch.push_back(8'($urandom_range(0, 255)));
         add_crlf();
      end
      add_hex(0);
      add_crlf();
      repeat ($urandom_range(0, 2)) add_trailer_line();
      add_crlf();
   endtask

   task automatic flush_scratch();
      foreach (scratch[i]) begin
         push_item(hcd_pkg::OP_BYTE, scratch[i]);
      end
      scratch.delete();
   endtask

   // hold until every item has gone in and every result has come back
   task automatic settle();
      do @(negedge clock);
      while (!(pending.size() == 0 && !req_ch.valid && expected.size() == 0));
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock);
      while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == ADDR_CHUNKED_MODE) begin
         chunked_cfg = value[0];
      end else begin
         length_cfg = value[hcd_pkg::CONTENT_LENGTH_WIDTH-1:0];
      end
   endtask

   task automatic set_config(input logic mode, input logic [31:0] len);
      csr_write(ADDR_CHUNKED_MODE, {31'd0, mode});
      csr_write(ADDR_CONTENT_LENGTH, len);
      @(negedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Input driver
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : drive_req
      body_item_type item;
      if (reset) begin
         req_ch.valid <= 1'b0;
         src_gap = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            decode_beat(req_ch.op, req_ch.data_in);
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (src_gap != 0 || pending.size() == 0) begin
               if (src_gap != 0) begin
                  src_gap--;
               end
               req_ch.valid <= 1'b0;
            end else begin
               item = pending.pop_front();
               req_ch.op      <= item.op;
               req_ch.data_in <= item.value;
               req_ch.valid   <= 1'b1;
               src_gap = src_idles ? $urandom_range(0, 4) : 0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result monitor
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : check_rsp
      body_beat_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         sink_gap = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected.size() == 0) begin
               $display("%0t: result beat with none expected: kind %0d data %02h",
                        $time, rsp_ch.kind, rsp_ch.data_out);
               errors++;
            end else begin
               want = expected.pop_front();
               if (rsp_ch.kind !== want.kind) begin
                  $display("%0t: kind mismatch: expected %0d actual %0d",
                           $time, want.kind, rsp_ch.kind);
                  errors++;
               end
               if (rsp_ch.data_out !== want.data) begin
                  $display("%0t: data_out mismatch: expected %02h actual %02h",
                           $time, want.data, rsp_ch.data_out);
                  errors++;
               end
            end
            sink_gap = sink_idles ? $urandom_range(0, 4) : 0;
         end
         if (sink_gap != 0) begin
            sink_gap--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin : stimulus
      logic [31:0] len;
      int unsigned n;
      int unsigned r;
      int unsigned k;
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.op      = hcd_pkg::OP_BYTE;
      req_ch.data_in = 8'd0;
      rsp_ch.ready   = 1'b0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = 3'd0;
      csr_pwdata     = 32'd0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: byte before any start, then a minimal chunked body
      src_idles  = 1'b1;
      sink_idles = 1'b1;
      push_item(hcd_pkg::OP_BYTE, 8'hA5);
      push_item(hcd_pkg::OP_START, 8'h00);
      add_text("1");
      add_crlf();
      scratch.push_back(8'hFF);
      add_crlf();
      add_text("0");
      add_crlf();
      add_text("a:");
      add_crlf();
      add_crlf();
      flush_scratch();
      settle();

      // length mode: empty body completes on the start itself
      set_config(1'b0, 32'd0);
      push_item(hcd_pkg::OP_START, 8'hFF);
      push_item(hcd_pkg::OP_BYTE, 8'h00);
      settle();
      set_config(1'b0, 32'd1);
      push_item(hcd_pkg::OP_START, 8'h00);
      push_item(hcd_pkg::OP_BYTE, 8'h00);
      push_item(hcd_pkg::OP_BYTE, 8'hFF);
      push_item(hcd_pkg::OP_BYTE, 8'h5A);
      settle();
      set_config(1'b0, 32'h7FFF_FFFF);
      push_item(hcd_pkg::OP_START, 8'h00);
      push_item(hcd_pkg::OP_BYTE, 8'h7F);
      settle();

      while (items_pushed < ITEM_TARGET) begin
         r = $urandom_range(0, 15);
         if (r == 0) begin
            len = 32'd0;
         end else if (r == 1) begin
            len = 32'h7FFF_FFFF;
         end else if (r == 2) begin
            len = $urandom;
         end else begin
            len = $urandom_range(1, 24);
         end
         set_config($urandom_range(0, 3) != 0, len);
         src_idles  = $urandom_range(0, 2) != 0;
         sink_idles = $urandom_range(0, 2) != 0;

         repeat ($urandom_range(2, 6)) begin
            if (!chunked_cfg) begin
               push_item(hcd_pkg::OP_START, 8'($urandom));
               if (length_cfg <= 64) begin
                  n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, length_cfg)
                                                  : length_cfg + $urandom_range(0, 3);
               end else begin
                  n = $urandom_range(0, 12);
               end
               repeat (n) push_item(hcd_pkg::OP_BYTE, 8'($urandom));
            end else begin
               r = $urandom_range(0, 15);
               if (r == 15) begin
                  // raw noise, starts included
                  repeat ($urandom_range(1, 8)) begin
                     push_item($urandom_range(0, 7) != 0, 8'($urandom));
                  end
               end else begin
                  if (r == 14) begin
                     // size line at or beyond the size limit
                     k = $urandom_range(0, 2);
                     len = (k == 0) ? 32'h7FFF_FFFF :
                           (k == 1) ? 32'h8000_0000 : ($urandom | 32'h0800_0000);
                     add_hex(len);
                     add_crlf();
                     repeat ($urandom_range(0, 4)) begin
                        scratch.push_back(8'($urandom_range(0, 255)));
                     end
                  end else begin
                     make_chunked_body();
                  end
                  if (r == 11 || r == 12) begin
                     k = $urandom_range(0, scratch.size() - 1);
                     case ($urandom_range(0, 4))
                        0:       scratch[k] = hcd_pkg::CH_CR;
                        1:       scratch[k] = hcd_pkg::CH_LF;
                        2:       scratch[k] = hcd_pkg::CH_COLON;
                        3:       scratch[k] = 8'h30;
                        default: scratch[k] = 8'($urandom_range(0, 255));
                     endcase
                  end else if (r == 13) begin
                     // drop the tail, the next start cuts the body short
                     k = $urandom_range(0, scratch.size() - 1);
                     while (scratch.size() > k) void'(scratch.pop_back());
                  end
                  push_item(hcd_pkg::OP_START, 8'($urandom));
                  flush_scratch();
               end
            end
         end
         settle();
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/hcd_pkg.sv
hdl/hcd_req_if.sv
hdl/hcd_rsp_if.sv
hdl/hcd_csr.sv
hdl/hcd_step.sv
hdl/http_chunked_body_decoder.sv
bench/http_chunked_body_decoder_tb.sv
